@@ sv/vt4_pkg.sv @@
// Shared types and constants for the 4x4 vertex transform block.
`default_nettype none

package vt4_pkg;

	// Element and vertex component width, signed fixed point
	localparam int WORD_WIDTH = 32;
	// Default fraction bits of the fixed-point format
	localparam int FRAC_BITS = 16;
	// Queue between the front and back ends; a power of two so pointers wrap
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_XFORM = 1'b1
	} op_t;

	// One queued transaction. For a load, data[0] holds the element value.
	// For a transform, data[0..3] hold x, y, z and w.
	typedef struct packed {
		op_t                              op;
		logic [1:0]                       col;
		logic [1:0]                       row;
		logic [3:0][WORD_WIDTH-1:0]       data;
	} item_t;

endpackage

`default_nettype wire

@@ sv/vt4_front.sv @@
// Front end: accepts transactions, classifies them and queues them.
`default_nettype none

module vt4_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cmd_valid,
	output logic                                  cmd_stall,
	input  wire logic                             operation,
	input  wire logic [1:0]                       column_index,
	input  wire logic [1:0]                       row_index,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] element_value,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] vec_x,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] vec_y,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] vec_z,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] vec_w,
	output vt4_pkg::item_t                        head,
	output logic                                  head_valid,
	input  wire logic                             pop
);

	vt4_pkg::item_t              queue_q [vt4_pkg::QUEUE_DEPTH];
	logic [vt4_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [vt4_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [vt4_pkg::QCNT_W-1:0]  count_q;
	vt4_pkg::item_t              new_item;
	logic                        push;
	logic                        do_pop;

	assign cmd_stall  = (count_q == vt4_pkg::QCNT_W'(vt4_pkg::QUEUE_DEPTH));
	assign push       = cmd_valid && !cmd_stall;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = queue_q[rd_ptr_q];

	// Classify: a load carries only its element, a transform its vertex
	always_comb begin
		new_item.op  = vt4_pkg::op_t'(operation);
		new_item.col = column_index;
		new_item.row = row_index;
		if (vt4_pkg::op_t'(operation) == vt4_pkg::OP_LOAD) begin
			new_item.data = {{(3*vt4_pkg::WORD_WIDTH){1'b0}}, element_value};
		end else begin
			new_item.data = {vec_w, vec_z, vec_y, vec_x};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vt4_pkg::QCNT_W'(vt4_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

@@ sv/vt4_back.sv @@
// Back end: holds the matrix, applies loads, runs the multiply-sum pipeline.
`default_nettype none

module vt4_back #(
	parameter int FRAC_BITS = vt4_pkg::FRAC_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire vt4_pkg::item_t                   head,
	input  wire logic                             head_valid,
	output logic                                  pop,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output logic signed [vt4_pkg::WORD_WIDTH-1:0] out_x,
	output logic signed [vt4_pkg::WORD_WIDTH-1:0] out_y,
	output logic signed [vt4_pkg::WORD_WIDTH-1:0] out_z,
	output logic signed [vt4_pkg::WORD_WIDTH-1:0] out_w
);

	localparam int W      = vt4_pkg::WORD_WIDTH;
	localparam int PROD_W = 2 * W;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	logic                     advance;
	logic                     load_now;
	logic                     v_s1;
	logic                     v_s2;
	logic signed [W-1:0]      mat_q  [4][4];
	logic signed [PROD_W-1:0] prod_s1 [4][4];
	logic signed [W-1:0]      res_s2 [4];

	assign advance   = !v_s2 || !res_stall;
	assign pop       = head_valid && advance;
	assign load_now  = pop && (head.op == vt4_pkg::OP_LOAD);
	assign res_valid = v_s2;
	assign out_x     = res_s2[0];
	assign out_y     = res_s2[1];
	assign out_z     = res_s2[2];
	assign out_w     = res_s2[3];

	for (genvar gc = 0; gc < 4; gc++) begin : g_col
		for (genvar gr = 0; gr < 4; gr++) begin : g_row
			logic signed [PROD_W-1:0] mul;
			logic signed [PROD_W-1:0] ma;
			logic signed [PROD_W-1:0] va;

			// Element write; diagonal resets to one
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mat_q[gc][gr] <= (gc == gr) ? ONE : '0;
				end else if (load_now && head.col == 2'(gc) && head.row == 2'(gr)) begin
					mat_q[gc][gr] <= head.data[0];
				end
			end

			assign ma  = PROD_W'(mat_q[gc][gr]);
			assign va  = PROD_W'($signed(head.data[gc]));
			assign mul = ma * va;

			// Floor shift is wiring; register the scaled product
			always_ff @(posedge clk) begin
				if (advance) begin
					prod_s1[gr][gc] <= mul >>> FRAC_BITS;
				end
			end
		end
	end

	for (genvar gr = 0; gr < 4; gr++) begin : g_sum
		logic signed [SUM_W-1:0] sum;

		assign sum = SUM_W'(prod_s1[gr][0]) + SUM_W'(prod_s1[gr][1])
			+ SUM_W'(prod_s1[gr][2]) + SUM_W'(prod_s1[gr][3]);

		always_ff @(posedge clk) begin
			if (advance) begin
				if (sum > SAT_HI) begin
					res_s2[gr] <= SAT_HI[W-1:0];
				end else if (sum < SAT_LO) begin
					res_s2[gr] <= SAT_LO[W-1:0];
				end else begin
					res_s2[gr] <= sum[W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= pop && (head.op == vt4_pkg::OP_XFORM);
			v_s2 <= v_s1;
		end
	end

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_now |=> !v_s1)
		else $error("load transaction entered the product stage");

	a_xform_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.op == vt4_pkg::OP_XFORM) |=> v_s1)
		else $error("transform transaction lost at pop");

	a_stage_follow: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (v_s2 == $past(v_s1)))
		else $error("result stage out of step with product stage");

endmodule

`default_nettype wire

@@ sv/vertex_transform_4x4.sv @@
// Top level of the 4x4 homogeneous vertex transform block.
// A transform result is registered in order through the queue write, the
// product stage, and the sum and saturate stage.
// Throughput: one transaction per cycle while the result channel is not stalled,
// set by the fully parallel bank of sixteen multipliers; load transactions produce no result.
// Reset: arst_n clears the queue and pipeline valids and restores the matrix
// to identity at once; the block accepts transactions on the next edge.
`default_nettype none

module vertex_transform_4x4 #(
	parameter int FRAC_BITS = vt4_pkg::FRAC_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Command channel: matrix loads and vertex transforms
	input  wire logic                                  cmd_valid,
	output logic                                       cmd_stall,
	input  wire logic                                  operation,
	input  wire logic [1:0]                            column_index,
	input  wire logic [1:0]                            row_index,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] element_value,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] vec_x,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] vec_y,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] vec_z,
	input  wire logic signed [vt4_pkg::WORD_WIDTH-1:0] vec_w,
	// Result channel: transformed vertices
	output logic                                       res_valid,
	input  wire logic                                  res_stall,
	output logic signed [vt4_pkg::WORD_WIDTH-1:0]      out_x,
	output logic signed [vt4_pkg::WORD_WIDTH-1:0]      out_y,
	output logic signed [vt4_pkg::WORD_WIDTH-1:0]      out_z,
	output logic signed [vt4_pkg::WORD_WIDTH-1:0]      out_w
);

	// Head of the queue as seen by the back end
	vt4_pkg::item_t head;
	logic           head_valid;
	logic           pop;

	// Front end: accept every transaction into a short queue; stall only
	// when the queue is full, so a stalled result does not block intake
	// until the queue has filled.
	vt4_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.operation     (operation),
		.column_index  (column_index),
		.row_index     (row_index),
		.element_value (element_value),
		.vec_x         (vec_x),
		.vec_y         (vec_y),
		.vec_z         (vec_z),
		.vec_w         (vec_w),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop)
	);

	// Back end: drain the queue in order. A load updates the matrix when it
	// is popped, so every transform sees exactly the loads that came before
	// it. A transform runs the products, then the row sums with saturation,
	// and holds its result in the output stage until it is taken.
	vt4_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_w      (out_w)
	);

endmodule

`default_nettype wire

@@ tb/sv/vertex_transform_4x4_test.sv @@
// Self-checking testbench for the 4x4 vertex transform block.
`default_nettype none

module vertex_transform_4x4_test;

	typedef logic signed [vt4_pkg::WORD_WIDTH-1:0] word_t;
	// Components indexed 0..3 as x, y, z, w
	typedef logic [3:0][vt4_pkg::WORD_WIDTH-1:0] vertex_t;

	localparam longint WORD_MAX     = 64'sd2147483647;
	localparam longint WORD_MIN     = -64'sd2147483648;
	localparam int     DRAIN_CYCLES = 8;
	localparam int     CYCLE_LIMIT  = 200000;
	localparam int     REPORT_LIMIT = 10;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cmd_valid;
	logic  cmd_stall;
	vt4_pkg::op_t operation;
	logic  [1:0] column_index;
	logic  [1:0] row_index;
	word_t element_value;
	word_t vec_x, vec_y, vec_z, vec_w;
	logic  res_valid;
	logic  res_stall;
	word_t out_x, out_y, out_z, out_w;

	// Shadow copy of the matrix, addressed [column][row]
	word_t   shadow_matrix [4][4];
	// Transformed vertices still owed by the block, oldest first
	vertex_t pending_vertices [$];
	// Component names for mismatch reports
	string   names [4] = '{"x", "y", "z", "w"};

	int mismatch_count = 0;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	vertex_transform_4x4 i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.operation    (operation),
		.column_index (column_index),
		.row_index    (row_index),
		.element_value(element_value),
		.vec_x        (vec_x),
		.vec_y        (vec_y),
		.vec_z        (vec_z),
		.vec_w        (vec_w),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.out_w        (out_w)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run: a hung handshake ends here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
				pending_vertices.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Throttle the result channel; a zero percentage leaves stall low throughout.
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// Restore the shadow matrix to identity, matching the block after reset.
	function automatic void reset_shadow_matrix();
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				shadow_matrix[c][r] = (c == r) ? word_t'(1 << vt4_pkg::FRAC_BITS) : '0;
	endfunction

	// Multiply the shadow matrix by one vertex. Each product is exact in 64 bits,
	// floored by the arithmetic shift, and the row sum clamps to the word range.
	function automatic vertex_t transform_with_shadow(vertex_t vtx);
		longint  row_sum;
		longint  product;
		vertex_t result;
		for (int r = 0; r < 4; r++) begin
			row_sum = 0;
			for (int c = 0; c < 4; c++) begin
				product = longint'(shadow_matrix[c][r]) * longint'($signed(vtx[c]));
				row_sum += product >>> vt4_pkg::FRAC_BITS;
			end
			if (row_sum > WORD_MAX)
				row_sum = WORD_MAX;
			else if (row_sum < WORD_MIN)
				row_sum = WORD_MIN;
			result[r] = row_sum[vt4_pkg::WORD_WIDTH-1:0];
		end
		return result;
	endfunction

	// Mix of full-range words, small and medium Q16.16 values, and extremes,
	// so that both saturated and in-range sums show up.
	function automatic word_t random_word();
		word_t extremes [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000};
		case ($urandom_range(3))
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(32'h0020_0000)) - word_t'(32'h0010_0000);
			2: return extremes[$urandom_range(5)];
			default: return word_t'($urandom_range(32'h0100_0000)) - word_t'(32'h0080_0000);
		endcase
	endfunction

	function automatic vertex_t random_vertex();
		vertex_t vtx;
		for (int i = 0; i < 4; i++)
			vtx[i] = random_word();
		return vtx;
	endfunction

	// Send one transaction: idle at random, hold the payload while stalled,
	// then update the shadow state at acceptance. Returns at a falling edge
	// with valid still high, so back-to-back transactions need no extra edge.
	task automatic issue_command(vt4_pkg::op_t op, logic [1:0] col, logic [1:0] row,
			word_t value, vertex_t vtx);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid     <= 1'b1;
		operation     <= op;
		column_index  <= col;
		row_index     <= row;
		element_value <= value;
		vec_x         <= vtx[0];
		vec_y         <= vtx[1];
		vec_z         <= vtx[2];
		vec_w         <= vtx[3];
		do
			@(posedge clk);
		while (cmd_stall);
		if (op == vt4_pkg::OP_LOAD)
			shadow_matrix[col][row] = value;
		else
			pending_vertices.push_back(transform_with_shadow(vtx));
		@(negedge clk);
	endtask

	// Vertex fields are don't-care on a load; fill them with noise.
	task automatic load_element(logic [1:0] col, logic [1:0] row, word_t value);
		issue_command(vt4_pkg::OP_LOAD, col, row, value, random_vertex());
	endtask

	// Address and element fields are don't-care on a transform; fill them with noise.
	task automatic transform_vertex(vertex_t vtx);
		issue_command(vt4_pkg::OP_XFORM, 2'($urandom), 2'($urandom), word_t'($urandom), vtx);
	endtask

	// Drop valid and hold off until every owed result is in, then let any
	// trailing load settle inside the pipeline.
	task automatic wait_for_results();
		cmd_valid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Compare each accepted result against the oldest owed vertex, component by component.
	always @(posedge clk) begin
		vertex_t got;
		vertex_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = {out_w, out_z, out_y, out_x};
			if (pending_vertices.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: result with nothing owed: x=%h y=%h z=%h w=%h", $realtime,
						out_x, out_y, out_z, out_w);
			end else begin
				want = pending_vertices.pop_front();
				for (int i = 0; i < 4; i++) begin
					if (got[i] !== want[i]) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("%0t: out_%s expected %h got %h", $realtime, names[i],
								want[i], got[i]);
					end
				end
			end
		end
	end

	// The matrix comes out of reset as identity: vertices pass through unchanged,
	// including the component extremes.
	task automatic test_identity_after_reset();
		sender_idle_pct    = 15;
		receiver_stall_pct = 79;
		transform_vertex({32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
		transform_vertex({32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001});
		transform_vertex(random_vertex());
		wait_for_results();
	endtask

	// Load extreme elements so that sums clamp in both directions, and a -1
	// element to check that the product shift floors toward minus infinity.
	task automatic test_loads_saturation_rounding();
		sender_idle_pct    = 15;
		receiver_stall_pct = 79;
		for (int c = 0; c < 4; c++)
			load_element(2'(c), 2'd0, 32'h7FFF_FFFF);
		for (int c = 0; c < 4; c++)
			load_element(2'(c), 2'd1, 32'h8000_0000);
		load_element(2'd0, 2'd2, 32'hFFFF_FFFF);
		load_element(2'd3, 2'd3, 32'h8000_0000);
		transform_vertex({4{32'h7FFF_FFFF}});
		transform_vertex({4{32'h8000_0000}});
		transform_vertex({32'h0, 32'h0, 32'h0, 32'h0000_0001});
		wait_for_results();
	endtask

	// Random loads and transforms. Now and then hold off until the pipeline
	// is empty, so the pause lands on different matrix contents.
	task automatic run_random_items(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(149) == 0)
				wait_for_results();
			if ($urandom_range(99) < 30)
				load_element(2'($urandom), 2'($urandom), random_word());
			else
				transform_vertex(random_vertex());
		end
		wait_for_results();
	endtask

	task automatic test_random_slow_receiver();
		sender_idle_pct    = 15;
		receiver_stall_pct = 79;
		run_random_items(470);
	endtask

	task automatic test_random_slow_sender();
		sender_idle_pct    = 79;
		receiver_stall_pct = 15;
		run_random_items(470);
	endtask

	task automatic test_random_full_rate();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		run_random_items(460);
	endtask

	initial begin
		// Drive every input to a known value before the first edge.
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		res_stall     = 1'b0;
		operation     = vt4_pkg::OP_LOAD;
		column_index  = '0;
		row_index     = '0;
		element_value = '0;
		vec_x         = '0;
		vec_y         = '0;
		vec_z         = '0;
		vec_w         = '0;
		reset_shadow_matrix();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_identity_after_reset();
		test_loads_saturation_rounding();
		test_random_slow_receiver();
		test_random_slow_sender();
		test_random_full_rate();

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/vt4_pkg.sv
sv/vt4_front.sv
sv/vt4_back.sv
sv/vertex_transform_4x4.sv
tb/sv/vertex_transform_4x4_test.sv
